FILE: rtl/odt_pkg.sv
// Shared types and constants for the obstacle distance transform.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`default_nettype none
package odt_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_W      = 9;
  localparam int COST_W     = 18;
  localparam int MPC_W      = 16;
  localparam int DIST_W     = 25;
  localparam int PROD_W     = COST_W + MPC_W;

  localparam logic [COST_W-1:0] COST_INF     = '1;
  localparam logic [COST_W:0]   STEP_STRAIGHT = (COST_W+1)'(256);
  localparam logic [COST_W:0]   STEP_DIAG     = (COST_W+1)'(362);

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_METERS_PER_CELL = 2'd2;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       col;
    logic [7:0]       row;
    logic signed [7:0] log_odds;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [DIST_W-1:0] distance_m;
    logic              reached;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic obs_wr;
    logic item_rd;
    logic prod_ld;
    logic out_ld;
    logic scan_fwd;
    logic scan_bwd;
    logic clr_changed;
    logic init_rd;
    logic init_wr;
    logic rd0;
    logic rd1;
    logic rd2;
    logic upd;
    logic step;
    logic computed_set;
  } odt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       in_range;
    logic       grid_empty;
    logic       scan_last;
    logic       any_change;
  } odt_sts_t;

endpackage
`default_nettype wire

FILE: rtl/odt_ctrl.sv
// Controller state machine of the obstacle distance transform.
// Uses odt_pkg; drives the datapath through odt_cmd_t and reads odt_sts_t.
`default_nettype none
module odt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire odt_pkg::odt_sts_t sts,
  output odt_pkg::odt_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DEC     = 4'd1;
  localparam logic [3:0] S_RDW     = 4'd2;
  localparam logic [3:0] S_DONE    = 4'd3;
  localparam logic [3:0] S_INIT_RD = 4'd4;
  localparam logic [3:0] S_INIT_WR = 4'd5;
  localparam logic [3:0] S_R0      = 4'd6;
  localparam logic [3:0] S_R1      = 4'd7;
  localparam logic [3:0] S_R2      = 4'd8;
  localparam logic [3:0] S_UPD     = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       bwd_r, bwd_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    bwd_nxt   = bwd_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.op)
          odt_pkg::OP_LOAD: begin
            cmd.obs_wr = sts.in_range;
            state_nxt  = S_DONE;
          end
          odt_pkg::OP_READ: begin
            cmd.item_rd = 1'b1;
            state_nxt   = S_RDW;
          end
          odt_pkg::OP_COMPUTE: begin
            if (sts.grid_empty) begin
              state_nxt = S_DONE;
            end else begin
              cmd.scan_fwd = 1'b1;
              state_nxt    = S_INIT_RD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_RDW: begin
        cmd.prod_ld = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_INIT_RD: begin
        cmd.init_rd = 1'b1;
        state_nxt   = S_INIT_WR;
      end
      S_INIT_WR: begin
        cmd.init_wr = 1'b1;
        cmd.step    = 1'b1;
        if (sts.scan_last) begin
          cmd.scan_fwd    = 1'b1;
          cmd.clr_changed = 1'b1;
          bwd_nxt         = 1'b0;
          state_nxt       = S_R0;
        end else begin
          state_nxt = S_INIT_RD;
        end
      end
      S_R0: begin
        cmd.rd0   = 1'b1;
        state_nxt = S_R1;
      end
      S_R1: begin
        cmd.rd1   = 1'b1;
        state_nxt = S_R2;
      end
      S_R2: begin
        cmd.rd2   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        cmd.step  = 1'b1;
        state_nxt = S_R0;
        if (sts.scan_last) begin
          if (!bwd_r) begin
            cmd.scan_bwd = 1'b1;
            bwd_nxt      = 1'b1;
          end else if (sts.any_change) begin
            cmd.scan_fwd    = 1'b1;
            cmd.clr_changed = 1'b1;
            bwd_nxt         = 1'b0;
          end else begin
            cmd.computed_set = 1'b1;
            state_nxt        = S_DONE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_ld) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bwd_r       <= bwd_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");
  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DEC))
    else $error("accepted transaction not decoded");
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == S_DONE))
    else $error("result appeared outside done state");
`endif

endmodule
`default_nettype wire

FILE: rtl/odt_dp.sv
// Datapath: config registers, obstacle and cost memories, scan counters,
// relaxation arithmetic and result register. Uses odt_pkg.
`default_nettype none
module odt_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire odt_pkg::in_item_t                   in_data,
  input  wire logic                                cfg_we,
  input  wire logic [odt_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [odt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire odt_pkg::odt_cmd_t                   cmd,
  output odt_pkg::odt_sts_t                        sts,
  output odt_pkg::out_item_t                       out_data
);

  localparam int CW = odt_pkg::COST_W;

  logic [odt_pkg::DIM_W-1:0] wreg_r, hreg_r;
  logic [odt_pkg::MPC_W-1:0] mpc_r;
  odt_pkg::in_item_t         item_r;
  odt_pkg::out_item_t        out_r;

  logic [odt_pkg::ROW_W-1:0] row_r;
  logic [odt_pkg::COL_W-1:0] col_r;
  logic                      dir_r, changed_r, computed_r;

  logic [CW-1:0] cs_r, n0_r, n1_r, n2_r;
  logic [CW-1:0] qa_r, qb_r;
  logic          obs_q_r;
  logic [odt_pkg::PROD_W-1:0] prod_r;
  logic          rch_r;

  logic                 obs_mem  [odt_pkg::DEPTH];
  logic [CW-1:0]        cost_mem [odt_pkg::DEPTH];

  logic [odt_pkg::DIM_W-1:0] eff_w, eff_h;
  logic [odt_pkg::COL_W-1:0] wm1;
  logic [odt_pkg::ROW_W-1:0] hm1;
  logic                      in_range;
  logic [odt_pkg::ADDR_W-1:0] item_addr, self_addr;
  logic [odt_pkg::ADDR_W-1:0] n0_addr, n1_addr, n2_addr, n3_addr;
  logic [odt_pkg::ADDR_W-1:0] addr_a, addr_b;
  logic [odt_pkg::COL_W-1:0] colp, colm;
  logic [odt_pkg::ROW_W-1:0] rowp;
  logic                      cp_ok, cm_ok, rp_ok;
  logic [CW:0]               best;
  logic                      improve;
  logic                      last;

  function automatic logic [CW:0] relax_min(input logic [CW:0] cur,
                                            input logic [CW-1:0] nb,
                                            input logic ok,
                                            input logic [CW:0] stp);
    logic [CW:0] cand;
    cand = {1'b0, nb} + stp;
    if (ok && (nb != odt_pkg::COST_INF) && (cand < cur)) return cand;
    return cur;
  endfunction

  assign eff_w = (wreg_r > odt_pkg::DIM_W'(odt_pkg::MAX_WIDTH))
               ? odt_pkg::DIM_W'(odt_pkg::MAX_WIDTH) : wreg_r;
  assign eff_h = (hreg_r > odt_pkg::DIM_W'(odt_pkg::MAX_HEIGHT))
               ? odt_pkg::DIM_W'(odt_pkg::MAX_HEIGHT) : hreg_r;
  assign wm1 = odt_pkg::COL_W'(eff_w - odt_pkg::DIM_W'(1));
  assign hm1 = odt_pkg::ROW_W'(eff_h - odt_pkg::DIM_W'(1));

  assign in_range = ({1'b0, item_r.col} < eff_w) && ({1'b0, item_r.row} < eff_h);
  assign item_addr = {item_r.row, item_r.col};
  assign self_addr = {row_r, col_r};

  // neighbor geometry: forward pass looks left/up, backward pass right/down
  assign colp  = dir_r ? col_r + 1'b1 : col_r - 1'b1;
  assign colm  = dir_r ? col_r - 1'b1 : col_r + 1'b1;
  assign rowp  = dir_r ? row_r + 1'b1 : row_r - 1'b1;
  assign cp_ok = dir_r ? (col_r != wm1) : (col_r != '0);
  assign cm_ok = dir_r ? (col_r != '0)  : (col_r != wm1);
  assign rp_ok = dir_r ? (row_r != hm1) : (row_r != '0);
  assign n0_addr = {row_r, colp};
  assign n1_addr = {rowp, col_r};
  assign n2_addr = {rowp, colp};
  assign n3_addr = {rowp, colm};

  always_comb begin
    addr_a = item_addr;
    addr_b = n0_addr;
    if (cmd.item_rd) begin
      addr_a = item_addr;
    end else if (cmd.rd0) begin
      addr_a = self_addr;
      addr_b = n0_addr;
    end else if (cmd.rd1) begin
      addr_a = n1_addr;
      addr_b = n2_addr;
    end else if (cmd.rd2) begin
      addr_a = n3_addr;
    end
  end

  // qa_r holds the last neighbor during the update cycle
  always_comb begin
    best = {1'b0, cs_r};
    best = relax_min(best, n0_r, cp_ok, odt_pkg::STEP_STRAIGHT);
    best = relax_min(best, n1_r, rp_ok, odt_pkg::STEP_STRAIGHT);
    best = relax_min(best, n2_r, rp_ok && cp_ok, odt_pkg::STEP_DIAG);
    best = relax_min(best, qa_r, rp_ok && cm_ok, odt_pkg::STEP_DIAG);
  end
  assign improve = best < {1'b0, cs_r};

  assign last = dir_r ? (row_r == '0 && col_r == '0) : (row_r == hm1 && col_r == wm1);

  assign sts.op         = item_r.op;
  assign sts.in_range   = in_range;
  assign sts.grid_empty = (eff_w == '0) || (eff_h == '0);
  assign sts.scan_last  = last;
  assign sts.any_change = changed_r || (cmd.upd && improve);

  // memories
  always_ff @(posedge clk) begin
    if (cmd.obs_wr) obs_mem[item_addr] <= ~item_r.log_odds[7];
    if (cmd.init_rd) obs_q_r <= obs_mem[self_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.init_wr) begin
      cost_mem[self_addr] <= obs_q_r ? '0 : odt_pkg::COST_INF;
    end else if (cmd.upd && improve) begin
      cost_mem[self_addr] <= best[CW-1:0];
    end
    qa_r <= cost_mem[addr_a];
    qb_r <= cost_mem[addr_b];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= in_data;
    if (cmd.rd1) begin
      cs_r <= qa_r;
      n0_r <= qb_r;
    end
    if (cmd.rd2) begin
      n1_r <= qa_r;
      n2_r <= qb_r;
    end
    if (cmd.prod_ld) begin
      prod_r <= qa_r * mpc_r;
      rch_r  <= (qa_r != odt_pkg::COST_INF);
    end
    if (cmd.out_ld) begin
      out_r.status     <= ((item_r.op == odt_pkg::OP_LOAD) ||
                           (item_r.op == odt_pkg::OP_READ)) && !in_range;
      out_r.reached    <= 1'b0;
      out_r.distance_m <= '0;
      if (item_r.op == odt_pkg::OP_READ && in_range && computed_r && rch_r) begin
        out_r.reached    <= 1'b1;
        out_r.distance_m <= prod_r[odt_pkg::DIST_W+7:8];
      end
    end
  end
  assign out_data = out_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wreg_r     <= odt_pkg::DIM_W'(256);
      hreg_r     <= odt_pkg::DIM_W'(256);
      mpc_r      <= odt_pkg::MPC_W'(3277);
      row_r      <= '0;
      col_r      <= '0;
      dir_r      <= 1'b0;
      changed_r  <= 1'b0;
      computed_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          odt_pkg::REG_GRID_WIDTH:      wreg_r <= cfg_wdata[odt_pkg::DIM_W-1:0];
          odt_pkg::REG_GRID_HEIGHT:     hreg_r <= cfg_wdata[odt_pkg::DIM_W-1:0];
          odt_pkg::REG_METERS_PER_CELL: mpc_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.computed_set) computed_r <= 1'b1;
      if (cmd.clr_changed) changed_r <= 1'b0;
      else if (cmd.upd && improve) changed_r <= 1'b1;
      if (cmd.scan_fwd) begin
        row_r <= '0;
        col_r <= '0;
        dir_r <= 1'b0;
      end else if (cmd.scan_bwd) begin
        row_r <= hm1;
        col_r <= wm1;
        dir_r <= 1'b1;
      end else if (cmd.step) begin
        if (!dir_r) begin
          if (col_r == wm1) begin
            col_r <= '0;
            row_r <= row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end else begin
          if (col_r == '0) begin
            col_r <= wm1;
            row_r <= row_r - 1'b1;
          end else begin
            col_r <= col_r - 1'b1;
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_write_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> ({1'b0, col_r} < eff_w && {1'b0, row_r} < eff_h))
    else $error("relaxation outside configured grid");
  a_cost_never_rises: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd && improve) |-> (best[CW-1:0] < cs_r))
    else $error("relaxation raised a cost");
  a_changed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd && improve && !cmd.clr_changed) |=> changed_r)
    else $error("change flag lost");
`endif

endmodule
`default_nettype wire

FILE: rtl/obstacle_distance_transform.sv
// Top level of the obstacle distance transform: controller plus datapath.
// Uses odt_pkg, odt_ctrl and odt_dp.
//
//   channel | ports                            | moves
//   in      | in_valid, in_stall, in_data      | op/col/row/log_odds transaction
//   out     | out_valid, out_stall, out_data   | status/distance_m/reached
//   cfg     | cfg_we, cfg_idx, cfg_wdata       | register write, no wait
//
// One item at a time: a load writes the obstacle memory, a read does one
// memory read and one multiply; each then loads the result register. A compute
// runs an init pass, then forward/backward sweep pairs until no cost changes;
// each cell passes S_R0, S_R1, S_R2 and S_UPD, set by the cost memory's two
// read ports. Reset is synchronous; memories are not cleared. A stalled result
// holds in the output register while the next transaction is accepted.
`default_nettype none
module obstacle_distance_transform (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire odt_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output odt_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [odt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [odt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  odt_pkg::odt_cmd_t cmd;
  odt_pkg::odt_sts_t sts;

  odt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  odt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
